// ===== hw/rtl/bps_pkg.sv =====
package bps_pkg;

    localparam int PACK_COUNT = 2;
    localparam int PIDX_W     = (PACK_COUNT > 1) ? $clog2(PACK_COUNT) : 1;
    localparam int CNT_W      = $clog2(PACK_COUNT + 1);

    localparam int MASK_W     = 2;
    localparam int MV_W       = 16;
    localparam int SOC_W      = 7;
    localparam int TEMP_W     = 8;
    localparam int SUM_W      = SOC_W + 1;
    localparam int CMP_W      = MV_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_PACK_MASK     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_CRIT_MV  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DCHG_STOP_MV  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DCHG_STOP_SOC = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CHG_STOP_MV   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HEAT_MIN_SOC  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COLD_LIMIT    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_WARM_LIMIT    = 3'd7;

    localparam logic [MASK_W-1:0]        RST_PACK_MASK     = 2'd3;
    localparam logic [MV_W-1:0]          RST_CELL_CRIT_MV  = 16'd2850;
    localparam logic [MV_W-1:0]          RST_DCHG_STOP_MV  = 16'd3000;
    localparam logic [SOC_W-1:0]         RST_DCHG_STOP_SOC = 7'd20;
    localparam logic [MV_W-1:0]          RST_CHG_STOP_MV   = 16'd4100;
    localparam logic [SOC_W-1:0]         RST_HEAT_MIN_SOC  = 7'd25;
    localparam logic signed [TEMP_W-1:0] RST_COLD_LIMIT    = -8'sd5;
    localparam logic signed [TEMP_W-1:0] RST_WARM_LIMIT    = 8'sd5;

    localparam logic [SUM_W-1:0] NO_PACK_SOC = 8'd50;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CELL_ONE,
        ST_CELL_TWO,
        ST_DCHG_MV,
        ST_DCHG_SOC,
        ST_CHG_MV,
        ST_STORE,
        ST_ROUND,
        ST_TEMP_COLD,
        ST_TEMP_WARM,
        ST_MEAN,
        ST_DECIDE,
        ST_OUT
    } bps_state_t;

endpackage

// ===== hw/rtl/battery_pack_supervisor_core.sv =====
// Battery pack supervisor.
// Input channel (s_valid/s_ready): one measurement record per pack. Result
// channel (m_valid/m_ready): one beat per record with the pack's charge and
// discharge disable bits, heater drive, critical-low flag and round marker.
// Config port: cfg_wr_en/cfg_index/cfg_wdata; the user writes it only while idle, not enforced.
// Every compare goes through one shared 17-bit signed comparator stepped by
// the sequencer, so a record takes one comparator slot per test:
//   - every record: cell one, cell two, discharge mV, discharge SoC and
//     charge mV tests, then a store step before its result
//   - the closing record, critical or forced off: a round step as well
//   - the closing record with a heater decision: round, a cold and a warm
//     compare per pack (die temperature if none enabled), mean, decide
// The block takes one record at a time; s_ready is high only when idle.
// The result sits in an output register; a stalled receiver holds the
// finished result and the next record can be accepted meanwhile, but that
// record waits in its final step until the register frees up.
// Reset (aresetn low, synchronous) restores register defaults, heater off,
// not heating, and clears the stored pack records.
module battery_pack_supervisor_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [bps_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bps_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_pack_index,
    input  logic                                s_data_valid,
    input  logic [bps_pkg::SOC_W-1:0]           s_state_of_charge,
    input  logic signed [bps_pkg::TEMP_W-1:0]   s_avg_temp_c,
    input  logic [bps_pkg::MV_W-1:0]            s_vcell_mv,
    input  logic [bps_pkg::MV_W-1:0]            s_cell_one_mv,
    input  logic [bps_pkg::MV_W-1:0]            s_cell_two_mv,
    input  logic signed [bps_pkg::TEMP_W-1:0]   s_die_temp_c,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_pack_id,
    output logic                                m_discharge_disable,
    output logic                                m_charge_disable,
    output logic                                m_heater_drive,
    output logic                                m_cell_crit,
    output logic                                m_round_done
);
    import bps_pkg::*;

    // configuration
    logic [MASK_W-1:0]        mask_reg;
    logic [MV_W-1:0]          cell_crit_mv_reg;
    logic [MV_W-1:0]          dchg_mv_reg;
    logic [SOC_W-1:0]         dchg_soc_reg;
    logic [MV_W-1:0]          chg_mv_reg;
    logic [SOC_W-1:0]         heat_soc_reg;
    logic signed [TEMP_W-1:0] cold_lim_reg;
    logic signed [TEMP_W-1:0] warm_lim_reg;

    // captured record
    logic                     idx_reg;
    logic                     valid_reg;
    logic [SOC_W-1:0]         soc_reg;
    logic signed [TEMP_W-1:0] temp_reg;
    logic [MV_W-1:0]          vcell_reg;
    logic [MV_W-1:0]          c1_reg;
    logic [MV_W-1:0]          c2_reg;
    logic signed [TEMP_W-1:0] die_reg;

    // per-pack store
    logic [SOC_W-1:0]         st_soc_reg   [PACK_COUNT];
    logic signed [TEMP_W-1:0] st_temp_reg  [PACK_COUNT];
    logic [PACK_COUNT-1:0]    st_valid_reg;
    logic [PACK_COUNT-1:0]    st_low_reg;

    // sequencer and working flags
    bps_state_t               state_reg, state_next;
    logic [PIDX_W-1:0]        p_reg, p_next;
    logic [SUM_W-1:0]         sum_reg, sum_next;
    logic                     low_reg, low_next;
    logic                     dchg_reg, dchg_next;
    logic                     chg_reg, chg_next;
    logic                     cold_reg, cold_next;
    logic                     warm_reg, warm_next;
    logic                     full_reg, full_next;
    logic                     crit_reg, crit_next;
    logic                     done_reg, done_next;
    logic                     heat_mode_reg, heat_mode_next;
    logic                     heater_reg, heater_next;

    // output register
    logic                     m_valid_reg, m_valid_next;
    logic                     o_pack_reg;
    logic                     o_dchg_reg;
    logic                     o_chg_reg;
    logic                     o_heat_reg;
    logic                     o_crit_reg;
    logic                     o_done_reg;
    logic                     o_load;

    // shared comparator
    logic signed [CMP_W-1:0]  cmp_a, cmp_b;
    logic                     cmp_lt;

    logic [PACK_COUNT+MASK_W-1:0] mask_ext;
    logic [PACK_COUNT-1:0]        en;
    logic [CNT_W-1:0]             usable;
    logic                         idx_ok;
    logic                         idx_last;
    logic [PACK_COUNT-1:0]        st_we;
    logic signed [TEMP_W-1:0]     cur_temp;
    logic [SUM_W-1:0]             total;
    logic                         s_accept;

    assign mask_ext = {{PACK_COUNT{1'b0}}, mask_reg};
    assign en       = mask_ext[PACK_COUNT-1:0];
    assign usable   = CNT_W'($countones(en));
    assign idx_ok   = 32'(idx_reg) < PACK_COUNT;
    assign idx_last = 32'(idx_reg) == PACK_COUNT - 1;
    assign cur_temp = (usable == '0) ? die_reg : st_temp_reg[p_reg];
    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign o_load   = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    always_comb begin
        if (usable == '0) begin
            total = NO_PACK_SOC;
        end else if (usable == CNT_W'(1)) begin
            total = sum_reg;
        end else begin
            total = sum_reg >> 1;
        end
    end

    always_comb begin
        for (int i = 0; i < PACK_COUNT; i++) begin
            st_we[i] = (state_reg == ST_STORE) && idx_ok && (32'(idx_reg) == i);
        end
    end

    always_comb begin
        cmp_a = '0;
        cmp_b = '0;
        unique case (state_reg)
            ST_CELL_ONE: begin
                cmp_a = $signed({1'b0, c1_reg});
                cmp_b = $signed({1'b0, cell_crit_mv_reg});
            end
            ST_CELL_TWO: begin
                cmp_a = $signed({1'b0, c2_reg});
                cmp_b = $signed({1'b0, cell_crit_mv_reg});
            end
            ST_DCHG_MV: begin
                cmp_a = $signed({1'b0, vcell_reg});
                cmp_b = $signed({1'b0, dchg_mv_reg});
            end
            ST_DCHG_SOC: begin
                cmp_a = $signed({{(CMP_W-SOC_W){1'b0}}, soc_reg});
                cmp_b = $signed({{(CMP_W-SOC_W){1'b0}}, dchg_soc_reg});
            end
            ST_CHG_MV: begin
                cmp_a = $signed({1'b0, chg_mv_reg});
                cmp_b = $signed({1'b0, vcell_reg});
            end
            ST_TEMP_COLD: begin
                cmp_a = CMP_W'(cur_temp);
                cmp_b = CMP_W'(cold_lim_reg);
            end
            ST_TEMP_WARM: begin
                cmp_a = CMP_W'(warm_lim_reg);
                cmp_b = CMP_W'(cur_temp);
            end
            ST_MEAN: begin
                cmp_a = $signed({{(CMP_W-SOC_W){1'b0}}, heat_soc_reg});
                cmp_b = $signed({{(CMP_W-SUM_W){1'b0}}, total});
            end
            default: begin
                cmp_a = '0;
                cmp_b = '0;
            end
        endcase
    end

    assign cmp_lt = cmp_a < cmp_b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            p_reg         <= '0;
            sum_reg       <= '0;
            low_reg       <= 1'b0;
            dchg_reg      <= 1'b0;
            chg_reg       <= 1'b0;
            cold_reg      <= 1'b0;
            warm_reg      <= 1'b0;
            full_reg      <= 1'b0;
            crit_reg      <= 1'b0;
            done_reg      <= 1'b0;
            heat_mode_reg <= 1'b0;
            heater_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            p_reg         <= p_next;
            sum_reg       <= sum_next;
            low_reg       <= low_next;
            dchg_reg      <= dchg_next;
            chg_reg       <= chg_next;
            cold_reg      <= cold_next;
            warm_reg      <= warm_next;
            full_reg      <= full_next;
            crit_reg      <= crit_next;
            done_reg      <= done_next;
            heat_mode_reg <= heat_mode_next;
            heater_reg    <= heater_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        p_next         = p_reg;
        sum_next       = sum_reg;
        low_next       = low_reg;
        dchg_next      = dchg_reg;
        chg_next       = chg_reg;
        cold_next      = cold_reg;
        warm_next      = warm_reg;
        full_next      = full_reg;
        crit_next      = crit_reg;
        done_next      = done_reg;
        heat_mode_next = heat_mode_reg;
        heater_next    = heater_reg;
        m_valid_next   = m_valid_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    crit_next  = 1'b0;
                    done_next  = 1'b0;
                    state_next = ST_CELL_ONE;
                end
            end
            ST_CELL_ONE: begin
                low_next   = cmp_lt;
                state_next = ST_CELL_TWO;
            end
            ST_CELL_TWO: begin
                low_next   = low_reg || cmp_lt;
                state_next = ST_DCHG_MV;
            end
            ST_DCHG_MV: begin
                dchg_next  = cmp_lt;
                state_next = ST_DCHG_SOC;
            end
            ST_DCHG_SOC: begin
                dchg_next  = dchg_reg || cmp_lt;
                state_next = ST_CHG_MV;
            end
            ST_CHG_MV: begin
                chg_next   = cmp_lt;
                state_next = ST_STORE;
            end
            ST_STORE: begin
                state_next = (idx_ok && idx_last) ? ST_ROUND : ST_OUT;
            end
            ST_ROUND: begin
                done_next = 1'b1;
                p_next    = '0;
                sum_next  = '0;
                cold_next = 1'b0;
                warm_next = 1'b0;
                if (|(en & st_low_reg)) begin
                    crit_next  = 1'b1;
                    state_next = ST_OUT;
                end else if ((&en) && (|(en & ~st_valid_reg))) begin
                    heater_next = 1'b0;
                    state_next  = ST_OUT;
                end else begin
                    state_next = ST_TEMP_COLD;
                end
            end
            ST_TEMP_COLD: begin
                cold_next = cold_reg || cmp_lt;
                if (en[p_reg]) begin
                    sum_next = sum_reg + SUM_W'(st_soc_reg[p_reg]);
                end
                state_next = ST_TEMP_WARM;
            end
            ST_TEMP_WARM: begin
                warm_next = warm_reg || cmp_lt;
                if ((usable == '0) || (32'(p_reg) == PACK_COUNT - 1)) begin
                    state_next = ST_MEAN;
                end else begin
                    p_next     = p_reg + PIDX_W'(1);
                    state_next = ST_TEMP_COLD;
                end
            end
            ST_MEAN: begin
                // no usable pack: assumed charge always counts as enough
                full_next  = (usable == '0) || cmp_lt;
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (heat_mode_reg) begin
                    heater_next = 1'b1;
                    if (warm_reg || !full_reg) begin
                        heat_mode_next = 1'b0;
                    end
                end else begin
                    heater_next = 1'b0;
                    if (cold_reg && full_reg) begin
                        heat_mode_next = 1'b1;
                    end
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (o_load) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // record capture
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            idx_reg   <= s_pack_index;
            valid_reg <= s_data_valid;
            soc_reg   <= s_state_of_charge;
            temp_reg  <= s_avg_temp_c;
            vcell_reg <= s_vcell_mv;
            c1_reg    <= s_cell_one_mv;
            c2_reg    <= s_cell_two_mv;
            die_reg   <= s_die_temp_c;
        end
    end

    // pack store
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= '0;
            st_low_reg   <= '0;
            for (int i = 0; i < PACK_COUNT; i++) begin
                st_soc_reg[i]  <= '0;
                st_temp_reg[i] <= '0;
            end
        end else begin
            for (int i = 0; i < PACK_COUNT; i++) begin
                if (st_we[i]) begin
                    st_soc_reg[i]   <= soc_reg;
                    st_temp_reg[i]  <= temp_reg;
                    st_valid_reg[i] <= valid_reg;
                    st_low_reg[i]   <= low_reg;
                end
            end
        end
    end

    // output beat
    always_ff @(posedge aclk) begin
        if (o_load) begin
            o_pack_reg <= idx_reg;
            o_dchg_reg <= !valid_reg || dchg_reg;
            o_chg_reg  <= !valid_reg || chg_reg;
            o_heat_reg <= heater_reg;
            o_crit_reg <= crit_reg;
            o_done_reg <= done_reg;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg         <= RST_PACK_MASK;
            cell_crit_mv_reg <= RST_CELL_CRIT_MV;
            dchg_mv_reg      <= RST_DCHG_STOP_MV;
            dchg_soc_reg     <= RST_DCHG_STOP_SOC;
            chg_mv_reg       <= RST_CHG_STOP_MV;
            heat_soc_reg     <= RST_HEAT_MIN_SOC;
            cold_lim_reg     <= RST_COLD_LIMIT;
            warm_lim_reg     <= RST_WARM_LIMIT;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_PACK_MASK:     mask_reg         <= cfg_wdata[MASK_W-1:0];
                REG_CELL_CRIT_MV:  cell_crit_mv_reg <= cfg_wdata[MV_W-1:0];
                REG_DCHG_STOP_MV:  dchg_mv_reg      <= cfg_wdata[MV_W-1:0];
                REG_DCHG_STOP_SOC: dchg_soc_reg     <= cfg_wdata[SOC_W-1:0];
                REG_CHG_STOP_MV:   chg_mv_reg       <= cfg_wdata[MV_W-1:0];
                REG_HEAT_MIN_SOC:  heat_soc_reg     <= cfg_wdata[SOC_W-1:0];
                REG_COLD_LIMIT:    cold_lim_reg     <= $signed(cfg_wdata[TEMP_W-1:0]);
                REG_WARM_LIMIT:    warm_lim_reg     <= $signed(cfg_wdata[TEMP_W-1:0]);
                default: begin
                end
            endcase
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_pack_id           = o_pack_reg;
    assign m_discharge_disable = o_dchg_reg;
    assign m_charge_disable    = o_chg_reg;
    assign m_heater_drive      = o_heat_reg;
    assign m_cell_crit         = o_crit_reg;
    assign m_round_done        = o_done_reg;

endmodule
